FILE: sv/tcqf_pkg.sv
// Shared constants, codes and types of the transmit character queue framer.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package tcqf_pkg;

  localparam int QUEUE_DEPTH  = 2048;
  localparam int AMBLE_LENGTH = 32;
  localparam int PTR_W        = $clog2(QUEUE_DEPTH);
  localparam int CNT_W        = 6;
  localparam int CHAR_W       = 8;
  localparam int WAIT_W       = 11;

  localparam logic [CNT_W-1:0]  AMBLE_END = CNT_W'(AMBLE_LENGTH);
  localparam logic [CHAR_W-1:0] BACKSPACE = 8'h08;

  localparam logic [2:0] OP_PUT_CHAR = 3'd0;
  localparam logic [2:0] OP_PUT_CTRL = 3'd1;
  localparam logic [2:0] OP_FETCH    = 3'd2;
  localparam logic [2:0] OP_CLEAR    = 3'd3;
  localparam logic [2:0] OP_START    = 3'd4;

  localparam logic [CHAR_W-1:0] CTL_AUTOSTOP = 8'd1;
  localparam logic [CHAR_W-1:0] CTL_NO_TAIL  = 8'd3;

  localparam logic [2:0] ST_OFF       = 3'd0;
  localparam logic [2:0] ST_TUNE      = 3'd1;
  localparam logic [2:0] ST_PREAMBLE  = 3'd2;
  localparam logic [2:0] ST_SENDING   = 3'd3;
  localparam logic [2:0] ST_POSTAMBLE = 3'd4;

  localparam logic [2:0] TK_NONE   = 3'd0;
  localparam logic [2:0] TK_CHAR   = 3'd1;
  localparam logic [2:0] TK_ON     = 3'd2;
  localparam logic [2:0] TK_TOGGLE = 3'd3;
  localparam logic [2:0] TK_OFF    = 3'd4;

  typedef struct packed {
    logic [2:0]        op;
    logic [CHAR_W-1:0] value;
    logic              start_tune;
  } req_t;

  typedef struct packed {
    logic [2:0] token_kind;
    logic [2:0] tx_state;
  } frame_res_t;

endpackage

FILE: sv/tcqf_if.sv
// Valid/ready channel interfaces for requests and results of the framer.
// Depends on tcqf_pkg for field widths.
`timescale 1ns / 1ps

interface tcqf_in_if;
  import tcqf_pkg::*;
  logic              valid;
  logic              ready;
  logic [2:0]        op;
  logic [CHAR_W-1:0] value;
  logic              start_tune;

  modport source (output valid, op, value, start_tune, input ready);
  modport sink   (input valid, op, value, start_tune, output ready);
endinterface

interface tcqf_out_if;
  import tcqf_pkg::*;
  logic              valid;
  logic              ready;
  logic              status;
  logic [2:0]        token_kind;
  logic [CHAR_W-1:0] token_char;
  logic [2:0]        tx_state;
  logic [WAIT_W-1:0] chars_waiting;

  modport source (output valid, status, token_kind, token_char, tx_state, chars_waiting,
                  input ready);
  modport sink   (input valid, status, token_kind, token_char, tx_state, chars_waiting,
                  output ready);
endinterface

FILE: sv/tcqf_char_ram.sv
// Character store of the transmit queue: one write port, one registered read port.
// Depends on tcqf_pkg for depth and widths.
`timescale 1ns / 1ps

module tcqf_char_ram
  import tcqf_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [PTR_W-1:0]  wr_addr,
  input  logic [CHAR_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [PTR_W-1:0]  rd_addr,
  output logic [CHAR_W-1:0] rd_data
);

  logic [CHAR_W-1:0] mem [QUEUE_DEPTH];
  logic [CHAR_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sv/tcqf_framer.sv
// Framing sequencer: state, amble counter and the auto-stop / no-tail flags.
// Depends on tcqf_pkg for codes and the request/result structs.
`timescale 1ns / 1ps

module tcqf_framer
  import tcqf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  req_t       req,
  input  logic       queue_empty,
  input  logic       commit,
  output frame_res_t res
);

  logic [2:0]       seq_state_r, seq_state_nxt;
  logic [CNT_W-1:0] amble_cnt_r, amble_cnt_nxt;
  logic             shutoff_armed_r, shutoff_armed_nxt;
  logic             no_tail_armed_r, no_tail_armed_nxt;
  logic             shutoff_pend_r, shutoff_pend_nxt;
  logic             no_tail_pend_r, no_tail_pend_nxt;
  logic [2:0]       kind;

  always_comb begin
    seq_state_nxt     = seq_state_r;
    amble_cnt_nxt     = amble_cnt_r;
    shutoff_armed_nxt = shutoff_armed_r;
    no_tail_armed_nxt = no_tail_armed_r;
    shutoff_pend_nxt  = shutoff_pend_r;
    no_tail_pend_nxt  = no_tail_pend_r;
    kind              = TK_NONE;
    case (req.op)
      OP_PUT_CTRL: begin
        if (req.value == CTL_AUTOSTOP) begin
          shutoff_armed_nxt = 1'b1;
          if (seq_state_r == ST_TUNE) begin
            shutoff_pend_nxt = 1'b1;
          end
        end else if (req.value == CTL_NO_TAIL) begin
          no_tail_armed_nxt = 1'b1;
        end
      end
      OP_FETCH: begin
        case (seq_state_r)
          ST_OFF: begin
            kind             = TK_OFF;
            shutoff_pend_nxt = 1'b0;
          end
          ST_TUNE: begin
            kind = TK_ON;
            if (shutoff_pend_r) begin
              kind             = TK_OFF;
              seq_state_nxt    = ST_OFF;
              amble_cnt_nxt    = '0;
              shutoff_pend_nxt = 1'b0;
            end
          end
          ST_PREAMBLE: begin
            kind = TK_TOGGLE;
            if (amble_cnt_r < AMBLE_END) begin
              amble_cnt_nxt = amble_cnt_r + 1'b1;
            end else begin
              seq_state_nxt = ST_SENDING;
              amble_cnt_nxt = '0;
            end
          end
          ST_SENDING: begin
            kind              = queue_empty ? TK_TOGGLE : TK_CHAR;
            shutoff_armed_nxt = 1'b0;
            no_tail_armed_nxt = 1'b0;
            shutoff_pend_nxt  = shutoff_pend_r | shutoff_armed_r;
            no_tail_pend_nxt  = no_tail_pend_r | no_tail_armed_r;
            if (queue_empty && (shutoff_pend_r || shutoff_armed_r)) begin
              seq_state_nxt = ST_POSTAMBLE;
            end
            amble_cnt_nxt = '0;
          end
          default: begin
            amble_cnt_nxt = amble_cnt_r + 1'b1;
            if ((amble_cnt_r >= AMBLE_END) || no_tail_pend_r) begin
              kind             = TK_OFF;
              no_tail_pend_nxt = 1'b0;
              seq_state_nxt    = ST_OFF;
              amble_cnt_nxt    = '0;
              shutoff_pend_nxt = 1'b0;
            end else begin
              kind = TK_ON;
            end
          end
        endcase
      end
      OP_CLEAR: begin
        no_tail_pend_nxt  = 1'b0;
        shutoff_armed_nxt = 1'b0;
        no_tail_armed_nxt = 1'b0;
      end
      OP_START: begin
        seq_state_nxt = req.start_tune ? ST_TUNE : ST_PREAMBLE;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_state_r     <= ST_PREAMBLE;
      amble_cnt_r     <= '0;
      shutoff_armed_r <= 1'b0;
      no_tail_armed_r <= 1'b0;
      shutoff_pend_r  <= 1'b0;
      no_tail_pend_r  <= 1'b0;
    end else if (commit) begin
      seq_state_r     <= seq_state_nxt;
      amble_cnt_r     <= amble_cnt_nxt;
      shutoff_armed_r <= shutoff_armed_nxt;
      no_tail_armed_r <= no_tail_armed_nxt;
      shutoff_pend_r  <= shutoff_pend_nxt;
      no_tail_pend_r  <= no_tail_pend_nxt;
    end
  end

  assign res.token_kind = kind;
  assign res.tx_state   = seq_state_nxt;

endmodule

FILE: sv/tx_char_queue_framer_unit.sv
// Transmit character queue framer: top level with queue pointers and result register.
// Depends on tcqf_pkg, tcqf_if, tcqf_char_ram and tcqf_framer.
`timescale 1ns / 1ps

// Every request has an accept step and an execute step: on acceptance the
// character store is read (the last queued entry for a put, the oldest entry
// for a fetch); once the output register is free the read data is used, the
// store and pointers are updated and the result is loaded into the output
// register. The store's single read port is the reason for the split; a new
// request is taken once the previous one has been written to the output
// register, so a result waiting to be taken does not hold off the next
// request. There is no clearing pass after reset: unwritten entries are never used.
module tx_char_queue_framer_unit
  import tcqf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  tcqf_in_if.sink    in_ch,
  tcqf_out_if.source out_ch
);

  localparam logic PH_IDLE = 1'b0;
  localparam logic PH_EXEC = 1'b1;

  logic              phase_r, phase_nxt;
  req_t              req_r;
  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [PTR_W-1:0]  tail_r, tail_nxt;
  logic              out_valid_r;
  logic              status_r;
  logic [2:0]        kind_r;
  logic [CHAR_W-1:0] char_r;
  logic [2:0]        tx_state_r;
  logic [WAIT_W-1:0] waiting_r;

  logic              accept;
  logic              commit;
  logic              out_free;
  logic [PTR_W-1:0]  rd_addr;
  logic [CHAR_W-1:0] rd_data;
  logic              wr_en;
  logic              append;
  logic              status;
  logic              queue_empty;
  logic              queue_full;
  frame_res_t        fr_res;
  logic [PTR_W-1:0]  occupancy;

  assign in_ch.ready = rst_n && (phase_r == PH_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign commit      = (phase_r == PH_EXEC) && out_free;
  assign queue_empty = (head_r == tail_r);
  assign queue_full  = ((head_r + 1'b1) == tail_r);
  assign rd_addr     = (in_ch.op == OP_FETCH) ? tail_r : (head_r - 1'b1);

  tcqf_char_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (head_r),
    .wr_data (req_r.value),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tcqf_framer u_framer (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (req_r),
    .queue_empty (queue_empty),
    .commit      (commit),
    .res         (fr_res)
  );

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    status   = 1'b0;
    append   = 1'b0;
    case (req_r.op)
      OP_PUT_CHAR: begin
        if ((req_r.value != BACKSPACE) || queue_empty || (rd_data == BACKSPACE)) begin
          if (queue_full) begin
            status = 1'b1;
          end else begin
            append   = 1'b1;
            head_nxt = head_r + 1'b1;
          end
        end else begin
          head_nxt = head_r - 1'b1;
        end
      end
      OP_FETCH: begin
        if (fr_res.token_kind == TK_CHAR) begin
          tail_nxt = tail_r + 1'b1;
        end
      end
      OP_CLEAR: begin
        head_nxt = '0;
        tail_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  assign wr_en     = commit && append;
  assign occupancy = head_nxt - tail_nxt;

  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_IDLE: begin
        if (accept) begin
          phase_nxt = PH_EXEC;
        end
      end
      default: begin
        if (commit) begin
          phase_nxt = PH_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      if (commit) begin
        head_r      <= head_nxt;
        tail_r      <= tail_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r.op         <= in_ch.op;
      req_r.value      <= in_ch.value;
      req_r.start_tune <= in_ch.start_tune;
    end
    if (commit) begin
      status_r   <= status;
      kind_r     <= fr_res.token_kind;
      char_r     <= (fr_res.token_kind == TK_CHAR) ? rd_data : '0;
      tx_state_r <= fr_res.tx_state;
      waiting_r  <= WAIT_W'(occupancy);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = status_r;
  assign out_ch.token_kind    = kind_r;
  assign out_ch.token_char    = char_r;
  assign out_ch.tx_state      = tx_state_r;
  assign out_ch.chars_waiting = waiting_r;

  a_char_only_on_dequeue: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.token_kind != TK_CHAR)) |-> (out_ch.token_char == '0))
    else $error("character byte on a non-character token");

  a_drop_only_on_put: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && status) |-> ((req_r.op == OP_PUT_CHAR) && queue_full))
    else $error("drop reported without a full queue on a put");

  a_append_advances_head: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && (req_r.op == OP_PUT_CHAR) && !status && (req_r.value != BACKSPACE))
      |=> (head_r == $past(head_r) + 1'b1))
    else $error("head did not advance on an accepted character");

  a_dequeue_advances_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && (fr_res.token_kind == TK_CHAR)) |=> (tail_r == $past(tail_r) + 1'b1))
    else $error("tail did not advance on a dequeued character");

endmodule

FILE: test/tx_char_queue_framer_unit_test.sv
// Self-checking test of tx_char_queue_framer_unit: directed and random requests with
// bursty sending and a stalling receiver, each result compared against a local model.
// Depends on tcqf_pkg, tcqf_if and the framer RTL.
`timescale 1ns / 1ps

module tx_char_queue_framer_unit_test;
  import tcqf_pkg::*;

  localparam int          CLK_PERIOD     = 12;
  localparam int          RESET_CYCLES   = 11;
  localparam int          RANDOM_ITEMS   = 1200;
  localparam int          DRAIN_CYCLES   = 20;
  localparam int          CYCLE_LIMIT    = 600000;
  localparam int          MAX_PRINTS     = 50;
  localparam int          REFILL_ROUNDS  = 64;
  localparam logic [2:0]  OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0]  OP_SPARE_LAST  = 3'd7;
  localparam logic [CHAR_W-1:0] CTL_IDENT = 8'd2;

  typedef struct packed {
    logic              status;
    logic [2:0]        token_kind;
    logic [CHAR_W-1:0] token_char;
    logic [2:0]        tx_state;
    logic [WAIT_W-1:0] chars_waiting;
  } frame_out_t;

  logic clk;
  logic rst_n;

  tcqf_in_if  in_ch();
  tcqf_out_if out_ch();

  tx_char_queue_framer_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // local copy of the framer
  logic [CHAR_W-1:0] char_copy [QUEUE_DEPTH];
  logic [PTR_W-1:0]  frame_head;
  logic [PTR_W-1:0]  frame_tail;
  logic [2:0]        frame_state;
  logic [CNT_W-1:0]  amble_cnt;
  logic              stop_armed;
  logic              notail_armed;
  logic              stop_pending;
  logic              notail_pending;

  frame_out_t  framer_outputs[$];
  int unsigned items_accepted;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic report_error(input string msg);
    if (error_count < MAX_PRINTS) begin
      $display("ERROR cycle %0d: %s", cycle_count, msg);
    end
    error_count++;
  endtask

  function automatic frame_out_t advance_framer(input req_t rq);
    frame_out_t       res;
    logic [PTR_W-1:0] next_head;
    logic [PTR_W-1:0] last;
    logic [PTR_W-1:0] diff;
    logic             ended;
    res       = '0;
    next_head = frame_head + 1'b1;
    last      = frame_head - 1'b1;
    case (rq.op)
      OP_PUT_CHAR: begin
        if (rq.value == BACKSPACE && frame_head != frame_tail &&
            char_copy[last] != BACKSPACE) begin
          frame_head = last;
        end else if (next_head == frame_tail) begin
          res.status = 1'b1;
        end else begin
          char_copy[frame_head] = rq.value;
          frame_head = next_head;
        end
      end
      OP_PUT_CTRL: begin
        if (rq.value == CTL_AUTOSTOP) begin
          stop_armed = 1'b1;
          if (frame_state == ST_TUNE) stop_pending = 1'b1;
        end else if (rq.value == CTL_NO_TAIL) begin
          notail_armed = 1'b1;
        end
      end
      OP_FETCH: begin
        case (frame_state)
          ST_OFF: begin
            res.token_kind = TK_OFF;
            stop_pending = 1'b0;
          end
          ST_TUNE: begin
            if (stop_pending) begin
              res.token_kind = TK_OFF;
              frame_state = ST_OFF;
              amble_cnt = '0;
              stop_pending = 1'b0;
            end else begin
              res.token_kind = TK_ON;
            end
          end
          ST_PREAMBLE: begin
            res.token_kind = TK_TOGGLE;
            if (amble_cnt < AMBLE_END) begin
              amble_cnt = amble_cnt + 1'b1;
            end else begin
              frame_state = ST_SENDING;
              amble_cnt = '0;
            end
          end
          ST_SENDING: begin
            if (frame_head != frame_tail) begin
              res.token_kind = TK_CHAR;
              res.token_char = char_copy[frame_tail];
              frame_tail = frame_tail + 1'b1;
            end else begin
              res.token_kind = TK_TOGGLE;
            end
            if (stop_armed) begin
              stop_armed = 1'b0;
              stop_pending = 1'b1;
            end
            if (notail_armed) begin
              notail_armed = 1'b0;
              notail_pending = 1'b1;
            end
            if (res.token_kind == TK_TOGGLE && stop_pending) frame_state = ST_POSTAMBLE;
            amble_cnt = '0;
          end
          default: begin
            ended = (amble_cnt >= AMBLE_END);
            amble_cnt = amble_cnt + 1'b1;
            if (ended || notail_pending) begin
              notail_pending = 1'b0;
              res.token_kind = TK_OFF;
              frame_state = ST_OFF;
              amble_cnt = '0;
              stop_pending = 1'b0;
            end else begin
              res.token_kind = TK_ON;
            end
          end
        endcase
      end
      OP_CLEAR: begin
        frame_head = '0;
        frame_tail = '0;
        notail_pending = 1'b0;
        stop_armed = 1'b0;
        notail_armed = 1'b0;
      end
      OP_START: begin
        frame_state = rq.start_tune ? ST_TUNE : ST_PREAMBLE;
      end
      default: begin
      end
    endcase
    diff = frame_head - frame_tail;
    res.tx_state = frame_state;
    res.chars_waiting = diff;
    return res;
  endfunction

  function automatic req_t make_req(input logic [2:0] op, input logic [CHAR_W-1:0] value,
                                    input logic tune);
    req_t rq;
    rq.op = op;
    rq.value = value;
    rq.start_tune = tune;
    return rq;
  endfunction

  function automatic logic [CHAR_W-1:0] random_char();
    if ($urandom_range(0, 4) == 0) return BACKSPACE;
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [CHAR_W-1:0] random_ctrl();
    case ($urandom_range(0, 3))
      0: return CTL_AUTOSTOP;
      1: return CTL_NO_TAIL;
      2: return CTL_IDENT;
      default: return CHAR_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Send one request; open a gap between bursts.
  task automatic send_request(input req_t rq);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(64, 200)
                                                : $urandom_range(1, 24);
      gap = $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        in_ch.valid = 1'b0;
        in_ch.op = 3'($urandom_range(0, 7));
        in_ch.value = CHAR_W'($urandom_range(0, 255));
        in_ch.start_tune = 1'($urandom_range(0, 1));
      end
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.op = rq.op;
    in_ch.value = rq.value;
    in_ch.start_tune = rq.start_tune;
    do @(posedge clk); while (!in_ch.ready);
    framer_outputs.push_back(advance_framer(rq));
    items_accepted++;
  endtask

  task automatic send_fetch();
    send_request(make_req(OP_FETCH, CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
  endtask

  task automatic send_put(input logic [CHAR_W-1:0] ch);
    send_request(make_req(OP_PUT_CHAR, ch, 1'b0));
  endtask

  task automatic send_ctrl(input logic [CHAR_W-1:0] code);
    send_request(make_req(OP_PUT_CTRL, code, 1'b0));
  endtask

  task automatic test_backspace_editing();
    send_request(make_req(OP_CLEAR, 8'h00, 1'b0));
    send_put(BACKSPACE);
    send_put(BACKSPACE);
    send_put(8'h41);
    send_put(BACKSPACE);
    send_put(8'h00);
    send_put(8'hFF);
    send_put(8'h55);
    send_put(8'hAA);
    send_put(BACKSPACE);
  endtask

  task automatic test_control_codes();
    logic [2:0] op;
    send_ctrl(CTL_IDENT);
    send_ctrl(8'hFF);
    send_ctrl(8'h00);
    for (op = OP_SPARE_FIRST; op <= OP_SPARE_LAST && op >= OP_SPARE_FIRST; op++) begin
      send_request(make_req(op, 8'hFF, 1'b1));
    end
  endtask

  task automatic test_framing_sequence();
    int unsigned i;
    send_request(make_req(OP_START, 8'h00, 1'b0));
    send_put(8'h48);
    send_put(8'h49);
    for (i = 0; i < 80 && frame_state != ST_SENDING; i++) send_fetch();
    send_fetch();
    send_fetch();
    send_fetch();
    send_ctrl(CTL_AUTOSTOP);
    for (i = 0; i < 80 && frame_state != ST_OFF; i++) send_fetch();
    send_fetch();
    // auto-stop with no tail: carrier off right after the first postamble fetch
    send_request(make_req(OP_START, 8'h00, 1'b0));
    send_ctrl(CTL_AUTOSTOP);
    send_ctrl(CTL_NO_TAIL);
    for (i = 0; i < 80 && frame_state != ST_OFF; i++) send_fetch();
  endtask

  task automatic test_tune_autostop();
    send_request(make_req(OP_START, 8'h00, 1'b1));
    send_fetch();
    send_ctrl(CTL_AUTOSTOP);
    send_fetch();
    send_fetch();
    send_request(make_req(OP_START, 8'h00, 1'b1));
    send_ctrl(CTL_AUTOSTOP);
    send_request(make_req(OP_CLEAR, 8'h00, 1'b0));
    send_fetch();
  endtask

  task automatic test_queue_full_and_wrap();
    int unsigned i;
    send_request(make_req(OP_CLEAR, 8'h00, 1'b0));
    // backspaces after backspaces are queued until the queue fills
    for (i = 0; i < QUEUE_DEPTH; i++) send_put(BACKSPACE);
    send_put(8'h7E);
    send_request(make_req(OP_START, 8'h00, 1'b0));
    for (i = 0; i < 80 && frame_state != ST_SENDING; i++) send_fetch();
    // drain a little while refilling so the head wraps
    for (i = 0; i < REFILL_ROUNDS; i++) begin
      send_fetch();
      if ($urandom_range(0, 1)) send_put(random_char());
    end
    send_request(make_req(OP_CLEAR, 8'h00, 1'b0));
  endtask

  task automatic test_random_traffic();
    int unsigned goal;
    int unsigned n;
    int unsigned i;
    int unsigned pick;
    int unsigned stop_at;
    goal = items_accepted + RANDOM_ITEMS;
    while (items_accepted < goal) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        n = $urandom_range(1, 8);
        repeat (n) begin
          send_request(make_req(3'($urandom_range(0, 7)), CHAR_W'($urandom_range(0, 255)),
                                1'($urandom_range(0, 1))));
        end
      end else if (pick == 1) begin
        send_request(make_req(OP_START, CHAR_W'($urandom_range(0, 255)), 1'b1));
        n = $urandom_range(1, 6);
        repeat (n) send_fetch();
        if ($urandom_range(0, 1)) send_ctrl(CTL_AUTOSTOP);
        n = $urandom_range(1, 4);
        repeat (n) send_fetch();
      end else begin
        send_request(make_req(OP_START, CHAR_W'($urandom_range(0, 255)), 1'b0));
        n = $urandom_range(0, 12);
        repeat (n) send_put(random_char());
        if ($urandom_range(0, 2) == 0) send_ctrl(CTL_NO_TAIL);
        stop_at = ($urandom_range(0, 4) == 0) ? 1000 : $urandom_range(5, 60);
        for (i = 0; i < 160 && frame_state != ST_OFF; i++) begin
          if (i == stop_at) send_ctrl(CTL_AUTOSTOP);
          pick = $urandom_range(0, 99);
          if (pick < 25) send_put(random_char());
          else if (pick < 30) send_ctrl(random_ctrl());
          else if (pick < 32) send_request(make_req(OP_CLEAR, CHAR_W'($urandom), 1'b0));
          else send_fetch();
        end
      end
    end
  endtask

  // receiver stall pattern: modes of random length
  initial begin
    int unsigned stall_mode;
    int unsigned mode_left;
    int unsigned phase;
    out_ch.ready = 1'b0;
    stall_mode = 0;
    mode_left = 0;
    phase = 0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(32, 256);
      end
      mode_left--;
      phase++;
      case (stall_mode)
        0: out_ch.ready = 1'b1;
        1: out_ch.ready = ($urandom_range(0, 3) == 0);
        2: out_ch.ready = 1'($urandom_range(0, 1));
        default: out_ch.ready = ((phase % 11) < 3);
      endcase
    end
  end

  always @(posedge clk) begin
    frame_out_t got;
    frame_out_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.status = out_ch.status;
      got.token_kind = out_ch.token_kind;
      got.token_char = out_ch.token_char;
      got.tx_state = out_ch.tx_state;
      got.chars_waiting = out_ch.chars_waiting;
      if (framer_outputs.size() == 0) begin
        report_error("result with no request outstanding");
      end else begin
        want = framer_outputs.pop_front();
        if (got.status !== want.status)
          report_error($sformatf("status %0h, want %0h", got.status, want.status));
        if (got.token_kind !== want.token_kind)
          report_error($sformatf("token_kind %0h, want %0h", got.token_kind,
                                 want.token_kind));
        if (got.token_char !== want.token_char)
          report_error($sformatf("token_char %0h, want %0h", got.token_char,
                                 want.token_char));
        if (got.tx_state !== want.tx_state)
          report_error($sformatf("tx_state %0h, want %0h", got.tx_state, want.tx_state));
        if (got.chars_waiting !== want.chars_waiting)
          report_error($sformatf("chars_waiting %0d, want %0d", got.chars_waiting,
                                 want.chars_waiting));
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_PUT_CHAR;
    in_ch.value = '0;
    in_ch.start_tune = 1'b0;
    items_accepted = 0;
    burst_left = 0;
    frame_head = '0;
    frame_tail = '0;
    frame_state = ST_PREAMBLE;
    amble_cnt = '0;
    stop_armed = 1'b0;
    notail_armed = 1'b0;
    stop_pending = 1'b0;
    notail_pending = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_backspace_editing();
    test_control_codes();
    test_framing_sequence();
    test_tune_autostop();
    test_queue_full_and_wrap();
    test_random_traffic();

    @(negedge clk);
    in_ch.valid = 1'b0;
    while (framer_outputs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (framer_outputs.size() != 0) report_error("results still outstanding at end");
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
